@@ sv/cllc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cllc_pkg;

   localparam int unsigned CODE_DIGITS   = 4;
   localparam int unsigned CODE_W        = 14;
   localparam int unsigned PERIOD_W      = 6;
   localparam int unsigned TRIAL_W       = 3;
   localparam int unsigned DIGIT_CNT_W   = 3;
   localparam int unsigned BLINK_W       = 2;
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = CODE_W;

   localparam logic [BLINK_W-1:0] LOCKOUT_BLINK = 2'd3;
   localparam logic [BLINK_W-1:0] ALARM_BLINK   = 2'd1;

   localparam logic [7:0] ASCII_LF   = 8'h0A;
   localparam logic [7:0] ASCII_CR   = 8'h0D;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   localparam logic [CODE_W-1:0]   RST_UNLOCK_CODE   = 14'd0;
   localparam logic [PERIOD_W-1:0] RST_ENTRY_TIMEOUT = 6'd10;
   localparam logic [PERIOD_W-1:0] RST_OPEN_TIME     = 6'd5;
   localparam logic [PERIOD_W-1:0] RST_DENIED_TIME   = 6'd5;
   localparam logic [PERIOD_W-1:0] RST_LOCKOUT_TIME  = 6'd15;
   localparam logic [PERIOD_W-1:0] RST_ALARM_TIME    = 6'd15;
   localparam logic [TRIAL_W-1:0]  RST_TRIAL_LIMIT   = 3'd3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_ENTRY   = 3'd1,
      MODE_GRANTED = 3'd2,
      MODE_DENIED  = 3'd3,
      MODE_LOCKOUT = 3'd4,
      MODE_TAMPER  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_ENTRY_START = 3'd1,
      EV_TIMEOUT     = 3'd2,
      EV_UNLOCK      = 3'd3,
      EV_LOCKOUT     = 3'd4,
      EV_DENIED      = 3'd5,
      EV_TAMPER      = 3'd6
   } event_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UNLOCK_CODE   = 3'd0,
      CSR_ENTRY_TIMEOUT = 3'd1,
      CSR_OPEN_TIME     = 3'd2,
      CSR_DENIED_TIME   = 3'd3,
      CSR_LOCKOUT_TIME  = 3'd4,
      CSR_ALARM_TIME    = 3'd5,
      CSR_TRIAL_LIMIT   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0]   unlock_code;
      logic [PERIOD_W-1:0] entry_timeout;
      logic [PERIOD_W-1:0] open_time;
      logic [PERIOD_W-1:0] denied_time;
      logic [PERIOD_W-1:0] lockout_time;
      logic [PERIOD_W-1:0] alarm_time;
      logic [TRIAL_W-1:0]  trial_limit;
   } cfg_type;

   typedef struct packed {
      logic       button_pressed;
      logic       byte_valid;
      logic [7:0] rx_byte;
      logic       time_tick;
   } req_type;

   typedef struct packed {
      logic [2:0] lock_state;
      logic       green_led;
      logic       red_led;
      logic       latch_drive;
      logic [2:0] event_code;
   } rsp_type;

   // a period of zero runs as one unit
   function automatic logic [PERIOD_W-1:0] nz_period(input logic [PERIOD_W-1:0] p);
      nz_period = (p == '0) ? PERIOD_W'(1) : p;
   endfunction

endpackage

`default_nettype wire

@@ sv/cllc_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cllc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [cllc_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  wire logic [cllc_pkg::CSR_DATA_W-1:0]  csr_data,
   output cllc_pkg::cfg_type                     cfg
);

   cllc_pkg::cfg_type cfg_ff;
   cllc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (cllc_pkg::csr_index_type'(csr_index))
            cllc_pkg::CSR_UNLOCK_CODE:   cfg_in.unlock_code   = csr_data;
            cllc_pkg::CSR_ENTRY_TIMEOUT: cfg_in.entry_timeout = csr_data[cllc_pkg::PERIOD_W-1:0];
            cllc_pkg::CSR_OPEN_TIME:     cfg_in.open_time     = csr_data[cllc_pkg::PERIOD_W-1:0];
            cllc_pkg::CSR_DENIED_TIME:   cfg_in.denied_time   = csr_data[cllc_pkg::PERIOD_W-1:0];
            cllc_pkg::CSR_LOCKOUT_TIME:  cfg_in.lockout_time  = csr_data[cllc_pkg::PERIOD_W-1:0];
            cllc_pkg::CSR_ALARM_TIME:    cfg_in.alarm_time    = csr_data[cllc_pkg::PERIOD_W-1:0];
            cllc_pkg::CSR_TRIAL_LIMIT:   cfg_in.trial_limit   = csr_data[cllc_pkg::TRIAL_W-1:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unlock_code   <= cllc_pkg::RST_UNLOCK_CODE;
         cfg_ff.entry_timeout <= cllc_pkg::RST_ENTRY_TIMEOUT;
         cfg_ff.open_time     <= cllc_pkg::RST_OPEN_TIME;
         cfg_ff.denied_time   <= cllc_pkg::RST_DENIED_TIME;
         cfg_ff.lockout_time  <= cllc_pkg::RST_LOCKOUT_TIME;
         cfg_ff.alarm_time    <= cllc_pkg::RST_ALARM_TIME;
         cfg_ff.trial_limit   <= cllc_pkg::RST_TRIAL_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/cllc_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cllc_fsm (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire cllc_pkg::req_type req,
   input  wire cllc_pkg::cfg_type cfg,
   output cllc_pkg::rsp_type      rsp
);

   localparam int unsigned CW = cllc_pkg::CODE_W;
   localparam int unsigned PW = cllc_pkg::PERIOD_W;
   localparam int unsigned TW = cllc_pkg::TRIAL_W;
   localparam int unsigned DW = cllc_pkg::DIGIT_CNT_W;
   localparam int unsigned BW = cllc_pkg::BLINK_W;

   cllc_pkg::mode_type  mode_ff, mode_in;
   logic                button_before_ff, button_before_in;
   logic [CW-1:0]       entered_ff, entered_in;
   logic [DW-1:0]       digit_count_ff, digit_count_in;
   logic [TW-1:0]       wrong_count_ff, wrong_count_in;
   logic [PW-1:0]       time_left_ff, time_left_in;
   logic                timer_running_ff, timer_running_in;
   logic                timer_expired_ff, timer_expired_in;
   logic                green_ff, green_in;
   logic                red_ff, red_in;
   logic [BW-1:0]       blink_divide_ff, blink_divide_in;
   logic [BW-1:0]       blink_count_ff, blink_count_in;
   logic                latch_ff, latch_in;

   logic                btn_rise;
   logic                is_digit;
   logic                is_eol;
   logic [CW-1:0]       value_next;
   logic [DW:0]         digits_next;
   logic [TW:0]         wrong_next;
   logic [TW-1:0]       limit_eff;
   logic [BW-1:0]       blink_inc;
   logic                code_ready;
   logic [CW-1:0]       code;
   cllc_pkg::event_type ev;

   assign btn_rise  = req.button_pressed & ~button_before_ff;
   assign is_digit  = (req.rx_byte >= cllc_pkg::ASCII_ZERO) &&
                      (req.rx_byte <= cllc_pkg::ASCII_NINE);
   assign is_eol    = (req.rx_byte == cllc_pkg::ASCII_CR) || (req.rx_byte == cllc_pkg::ASCII_LF);
   // value * 10 + digit, wrapping at the code width
   assign value_next = {entered_ff[CW-4:0], 3'b000} + {entered_ff[CW-2:0], 1'b0}
                     + {{(CW-4){1'b0}}, req.rx_byte[3:0]};
   assign digits_next = {1'b0, digit_count_ff} + (DW+1)'(1);
   assign wrong_next  = {1'b0, wrong_count_ff} + (TW+1)'(1);
   assign limit_eff   = (cfg.trial_limit == '0) ? TW'(1) : cfg.trial_limit;
   assign blink_inc   = blink_count_ff + BW'(1);

   always_comb begin
      mode_in          = mode_ff;
      button_before_in = req.button_pressed;
      entered_in       = entered_ff;
      digit_count_in   = digit_count_ff;
      wrong_count_in   = wrong_count_ff;
      time_left_in     = time_left_ff;
      timer_running_in = timer_running_ff;
      timer_expired_in = timer_expired_ff;
      green_in         = green_ff;
      red_in           = red_ff;
      blink_divide_in  = blink_divide_ff;
      blink_count_in   = blink_count_ff;
      latch_in         = latch_ff;
      code_ready       = 1'b0;
      code             = '0;
      ev               = cllc_pkg::EV_NONE;

      // timer advances before the state looks at it
      if (timer_running_ff && req.time_tick) begin
         if (time_left_ff <= PW'(1)) begin
            time_left_in     = '0;
            timer_running_in = 1'b0;
            timer_expired_in = 1'b1;
         end else begin
            time_left_in = time_left_ff - PW'(1);
         end
      end

      if (mode_ff == cllc_pkg::MODE_ENTRY && req.byte_valid) begin
         if (is_eol && digit_count_ff != '0) begin
            code           = entered_ff;
            code_ready     = 1'b1;
            entered_in     = '0;
            digit_count_in = '0;
         end else if (is_digit) begin
            if (digits_next >= (DW+1)'(cllc_pkg::CODE_DIGITS)) begin
               code           = value_next;
               code_ready     = 1'b1;
               entered_in     = '0;
               digit_count_in = '0;
            end else begin
               entered_in     = value_next;
               digit_count_in = digits_next[DW-1:0];
            end
         end
      end

      unique case (mode_ff)
         cllc_pkg::MODE_IDLE: begin
            if (btn_rise) begin
               mode_in          = cllc_pkg::MODE_ENTRY;
               entered_in       = '0;
               digit_count_in   = '0;
               time_left_in     = cllc_pkg::nz_period(cfg.entry_timeout);
               timer_running_in = 1'b1;
               timer_expired_in = 1'b0;
               ev               = cllc_pkg::EV_ENTRY_START;
            end
         end
         cllc_pkg::MODE_ENTRY: begin
            if (timer_expired_in) begin
               // timeout wins over a code finished in the same cycle
               mode_in          = cllc_pkg::MODE_IDLE;
               time_left_in     = '0;
               timer_running_in = 1'b0;
               timer_expired_in = 1'b0;
               entered_in       = '0;
               digit_count_in   = '0;
               ev               = cllc_pkg::EV_TIMEOUT;
            end else if (code_ready) begin
               if (code == cfg.unlock_code) begin
                  mode_in          = cllc_pkg::MODE_GRANTED;
                  time_left_in     = cllc_pkg::nz_period(cfg.open_time);
                  timer_running_in = 1'b1;
                  timer_expired_in = 1'b0;
                  green_in         = 1'b1;
                  latch_in         = 1'b1;
                  wrong_count_in   = '0;
                  ev               = cllc_pkg::EV_UNLOCK;
               end else if (wrong_next >= {1'b0, limit_eff}) begin
                  mode_in          = cllc_pkg::MODE_LOCKOUT;
                  time_left_in     = cllc_pkg::nz_period(cfg.lockout_time);
                  timer_running_in = 1'b1;
                  timer_expired_in = 1'b0;
                  wrong_count_in   = '0;
                  ev               = cllc_pkg::EV_LOCKOUT;
               end else begin
                  mode_in          = cllc_pkg::MODE_DENIED;
                  wrong_count_in   = wrong_next[TW-1:0];
                  red_in           = 1'b1;
                  blink_count_in   = '0;
                  time_left_in     = cllc_pkg::nz_period(cfg.denied_time);
                  timer_running_in = 1'b1;
                  timer_expired_in = 1'b0;
                  ev               = cllc_pkg::EV_DENIED;
               end
            end
         end
         cllc_pkg::MODE_GRANTED: begin
            if (timer_expired_in) begin
               mode_in          = cllc_pkg::MODE_IDLE;
               time_left_in     = '0;
               timer_running_in = 1'b0;
               timer_expired_in = 1'b0;
               green_in         = 1'b0;
               latch_in         = 1'b0;
            end
         end
         cllc_pkg::MODE_DENIED: begin
            // expired flag is left set here; the next timer start clears it
            if (timer_expired_in) begin
               mode_in        = cllc_pkg::MODE_IDLE;
               red_in         = 1'b0;
               blink_count_in = '0;
            end
         end
         cllc_pkg::MODE_LOCKOUT: begin
            if (timer_expired_in) begin
               mode_in          = cllc_pkg::MODE_IDLE;
               red_in           = 1'b0;
               blink_count_in   = '0;
               time_left_in     = '0;
               timer_running_in = 1'b0;
               timer_expired_in = 1'b0;
            end else if (btn_rise) begin
               mode_in          = cllc_pkg::MODE_TAMPER;
               time_left_in     = cllc_pkg::nz_period(cfg.alarm_time);
               timer_running_in = 1'b1;
               timer_expired_in = 1'b0;
               red_in           = 1'b0;
               blink_divide_in  = cllc_pkg::ALARM_BLINK;
               blink_count_in   = '0;
               ev               = cllc_pkg::EV_TAMPER;
            end else if (blink_inc >= blink_divide_ff) begin
               red_in         = ~red_ff;
               blink_count_in = '0;
            end else begin
               blink_count_in = blink_inc;
            end
         end
         cllc_pkg::MODE_TAMPER: begin
            if (timer_expired_in) begin
               mode_in          = cllc_pkg::MODE_IDLE;
               red_in           = 1'b0;
               blink_count_in   = '0;
               time_left_in     = '0;
               timer_running_in = 1'b0;
               timer_expired_in = 1'b0;
            end else if (blink_inc >= blink_divide_ff) begin
               red_in         = ~red_ff;
               blink_count_in = '0;
            end else begin
               blink_count_in = blink_inc;
            end
         end
         default: begin
            mode_in = cllc_pkg::MODE_IDLE;
         end
      endcase

      rsp.lock_state  = mode_in;
      rsp.green_led   = green_in;
      rsp.red_led     = red_in;
      rsp.latch_drive = latch_in;
      rsp.event_code  = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= cllc_pkg::MODE_IDLE;
         button_before_ff <= 1'b0;
         entered_ff       <= '0;
         digit_count_ff   <= '0;
         wrong_count_ff   <= '0;
         time_left_ff     <= '0;
         timer_running_ff <= 1'b0;
         timer_expired_ff <= 1'b0;
         green_ff         <= 1'b0;
         red_ff           <= 1'b0;
         blink_divide_ff  <= cllc_pkg::LOCKOUT_BLINK;
         blink_count_ff   <= '0;
         latch_ff         <= 1'b0;
      end else if (step) begin
         mode_ff          <= mode_in;
         button_before_ff <= button_before_in;
         entered_ff       <= entered_in;
         digit_count_ff   <= digit_count_in;
         wrong_count_ff   <= wrong_count_in;
         time_left_ff     <= time_left_in;
         timer_running_ff <= timer_running_in;
         timer_expired_ff <= timer_expired_in;
         green_ff         <= green_in;
         red_ff           <= red_in;
         blink_divide_ff  <= blink_divide_in;
         blink_count_ff   <= blink_count_in;
         latch_ff         <= latch_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/code_lock_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Code lock controller. Each input item is one control cycle (button level,
// optional received byte, timer tick) and yields exactly one result item
// (lock state, LEDs, latch drive, event number). Items pass through an input
// register and a result register with the lock's state update between them,
// and one item can be taken every cycle unless the result side stalls. The
// result register decouples the sides: a new item is still taken while the
// previous result waits, and stall on the request side rises only when both
// registers are full and the result side stalls. Configuration must be
// written through csr_write/csr_index/csr_data only while no item is in
// flight; the block itself does not enforce this. Unmapped indexes are
// ignored.
module code_lock_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire cllc_pkg::req_type                req_data,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output cllc_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_write,
   input  wire logic [cllc_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  wire logic [cllc_pkg::CSR_DATA_W-1:0]  csr_data
);

   cllc_pkg::cfg_type cfg;
   cllc_pkg::rsp_type rsp_next;

   logic              req_valid_ff, req_valid_in;
   cllc_pkg::req_type req_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cllc_pkg::rsp_type rsp_data_ff;

   logic              req_take;
   logic              rsp_take;
   logic              advance;

   cllc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cllc_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_data_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // item moves from the input register to the result register
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ tb/code_lock_checker.sv @@
`timescale 1ns / 1ps

module code_lock_checker
   import cllc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  req_type                    req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  rsp_type                    rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         error_count,
   output int                         pending_count
);

   cfg_type                cfg;
   mode_type               mode;
   logic                   button_last;
   logic [CODE_W-1:0]      entered;
   logic [DIGIT_CNT_W-1:0] digit_count;
   logic [TRIAL_W-1:0]     wrong_count;
   logic [PERIOD_W-1:0]    time_left;
   logic                   timer_on;
   logic                   timer_done;
   logic                   green_on;
   logic                   red_on;
   logic                   latch_open;
   logic [BLINK_W-1:0]     blink_div;
   logic [BLINK_W-1:0]     blink_count;
   rsp_type                awaited_status[$];

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   task automatic start_timer(input logic [PERIOD_W-1:0] period);
      time_left = (period == '0) ? PERIOD_W'(1) : period;
      timer_on = 1'b1;
      timer_done = 1'b0;
   endtask

   task automatic stop_timer();
      time_left = '0;
      timer_on = 1'b0;
      timer_done = 1'b0;
   endtask

   task automatic set_red(input logic on);
      red_on = on;
      blink_count = '0;
   endtask

   task automatic blink_red();
      blink_count = blink_count + 1'b1;
      if (blink_count >= blink_div) begin
         red_on = ~red_on;
         blink_count = '0;
      end
   endtask

   // one control cycle of the lock
   task automatic step_lock(input req_type item, output rsp_type status);
      logic              press_edge;
      logic              code_done;
      logic [CODE_W-1:0] code_val;
      event_type         note;
      int                trials;
      press_edge = item.button_pressed && !button_last;
      code_done = 1'b0;
      code_val = '0;
      note = EV_NONE;
      button_last = item.button_pressed;

      if (timer_on && item.time_tick) begin
         if (time_left <= 1) begin
            time_left = '0;
            timer_on = 1'b0;
            timer_done = 1'b1;
         end else begin
            time_left = time_left - 1'b1;
         end
      end

      // bytes only count when the cycle starts in entry
      if (mode == MODE_ENTRY && item.byte_valid) begin
         if ((item.rx_byte == ASCII_CR || item.rx_byte == ASCII_LF) && digit_count != 0) begin
            code_done = 1'b1;
            code_val = entered;
            entered = '0;
            digit_count = '0;
         end else if (item.rx_byte >= ASCII_ZERO && item.rx_byte <= ASCII_NINE) begin
            entered = CODE_W'(entered * 10 + (item.rx_byte - ASCII_ZERO));
            if (digit_count + 1 >= CODE_DIGITS) begin
               code_done = 1'b1;
               code_val = entered;
               entered = '0;
               digit_count = '0;
            end else begin
               digit_count = digit_count + 1'b1;
            end
         end
      end

      case (mode)
         MODE_IDLE: begin
            if (press_edge) begin
               mode = MODE_ENTRY;
               entered = '0;
               digit_count = '0;
               start_timer(cfg.entry_timeout);
               note = EV_ENTRY_START;
            end
         end
         MODE_ENTRY: begin
            trials = (cfg.trial_limit == '0) ? 1 : int'(cfg.trial_limit);
            // timeout wins over a code finished in the same cycle
            if (timer_done) begin
               mode = MODE_IDLE;
               stop_timer();
               entered = '0;
               digit_count = '0;
               note = EV_TIMEOUT;
            end else if (code_done) begin
               if (code_val == cfg.unlock_code) begin
                  mode = MODE_GRANTED;
                  start_timer(cfg.open_time);
                  green_on = 1'b1;
                  latch_open = 1'b1;
                  wrong_count = '0;
                  note = EV_UNLOCK;
               end else if (int'(wrong_count) + 1 >= trials) begin
                  mode = MODE_LOCKOUT;
                  start_timer(cfg.lockout_time);
                  wrong_count = '0;
                  note = EV_LOCKOUT;
               end else begin
                  wrong_count = wrong_count + 1'b1;
                  mode = MODE_DENIED;
                  set_red(1'b1);
                  start_timer(cfg.denied_time);
                  note = EV_DENIED;
               end
            end
         end
         MODE_GRANTED: begin
            if (timer_done) begin
               mode = MODE_IDLE;
               stop_timer();
               green_on = 1'b0;
               latch_open = 1'b0;
            end
         end
         MODE_DENIED: begin
            // expired flag stays set until the next timer start
            if (timer_done) begin
               mode = MODE_IDLE;
               set_red(1'b0);
            end
         end
         MODE_LOCKOUT: begin
            if (timer_done) begin
               mode = MODE_IDLE;
               set_red(1'b0);
               stop_timer();
            end else if (press_edge) begin
               mode = MODE_TAMPER;
               start_timer(cfg.alarm_time);
               set_red(1'b0);
               blink_div = ALARM_BLINK;
               blink_count = '0;
               note = EV_TAMPER;
            end else begin
               blink_red();
            end
         end
         MODE_TAMPER: begin
            if (timer_done) begin
               mode = MODE_IDLE;
               set_red(1'b0);
               stop_timer();
            end else begin
               blink_red();
            end
         end
         default: begin
            mode = MODE_IDLE;
         end
      endcase

      status.lock_state = mode;
      status.green_led = green_on;
      status.red_led = red_on;
      status.latch_drive = latch_open;
      status.event_code = note;
   endtask

   task automatic report_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type next_status;
      rsp_type want;
      if (reset) begin
         cfg.unlock_code = RST_UNLOCK_CODE;
         cfg.entry_timeout = RST_ENTRY_TIMEOUT;
         cfg.open_time = RST_OPEN_TIME;
         cfg.denied_time = RST_DENIED_TIME;
         cfg.lockout_time = RST_LOCKOUT_TIME;
         cfg.alarm_time = RST_ALARM_TIME;
         cfg.trial_limit = RST_TRIAL_LIMIT;
         mode = MODE_IDLE;
         button_last = 1'b0;
         entered = '0;
         digit_count = '0;
         wrong_count = '0;
         stop_timer();
         green_on = 1'b0;
         red_on = 1'b0;
         latch_open = 1'b0;
         blink_div = LOCKOUT_BLINK;
         blink_count = '0;
         awaited_status.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_UNLOCK_CODE:   cfg.unlock_code = csr_data[CODE_W-1:0];
               CSR_ENTRY_TIMEOUT: cfg.entry_timeout = csr_data[PERIOD_W-1:0];
               CSR_OPEN_TIME:     cfg.open_time = csr_data[PERIOD_W-1:0];
               CSR_DENIED_TIME:   cfg.denied_time = csr_data[PERIOD_W-1:0];
               CSR_LOCKOUT_TIME:  cfg.lockout_time = csr_data[PERIOD_W-1:0];
               CSR_ALARM_TIME:    cfg.alarm_time = csr_data[PERIOD_W-1:0];
               CSR_TRIAL_LIMIT:   cfg.trial_limit = csr_data[TRIAL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            step_lock(req_data, next_status);
            awaited_status.push_back(next_status);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               error_count++;
               $error("result item arrived with none expected: %p", rsp_data);
            end else begin
               want = awaited_status.pop_front();
               report_field("lock_state", want.lock_state, rsp_data.lock_state);
               report_field("green_led", want.green_led, rsp_data.green_led);
               report_field("red_led", want.red_led, rsp_data.red_led);
               report_field("latch_drive", want.latch_drive, rsp_data.latch_drive);
               report_field("event_code", want.event_code, rsp_data.event_code);
            end
         end
      end
      pending_count = awaited_status.size();
   end

endmodule

@@ tb/code_lock_controller_tb.sv @@
`timescale 1ns / 1ps

module code_lock_controller_tb;
   import cllc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int STALL_LIMIT     = 1000;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 115;
   localparam int HOLD_OFF_CYCLES = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic req_taken = 1'b0;
   logic req_burst = 1'b0;
   logic rsp_burst = 1'b0;
   logic hold_off = 1'b0;
   int   lock_errors;
   int   lock_pending;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   int   tick_pct = 20;
   int   tail_max = 10;
   int   code_now = 0;

   always #5 clock = ~clock;

   code_lock_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   code_lock_checker lock_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (lock_errors),
      .pending_count (lock_pending)
   );

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // no progress on either channel for too long ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic coin(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic req_type make_item(input logic pressed, input logic has_byte,
                                         input logic [7:0] rx, input logic tick);
      req_type item;
      item.button_pressed = pressed;
      item.byte_valid = has_byte;
      item.rx_byte = rx;
      item.time_tick = tick;
      return item;
   endfunction

   function automatic cfg_type make_cfg(input int code, input int entry, input int open,
                                        input int denied, input int lockout,
                                        input int alarm, input int trials);
      cfg_type c;
      c.unlock_code = CODE_W'(code);
      c.entry_timeout = PERIOD_W'(entry);
      c.open_time = PERIOD_W'(open);
      c.denied_time = PERIOD_W'(denied);
      c.lockout_time = PERIOD_W'(lockout);
      c.alarm_time = PERIOD_W'(alarm);
      c.trial_limit = TRIAL_W'(trials);
      return c;
   endfunction

   function automatic int pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 80) return $urandom_range(1, 6);
      return $urandom_range(1, 63);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (req_burst || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic drive_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(negedge clock); while (!req_taken);
      items_sent++;
   endtask

   task automatic put_reg(input logic [CSR_ADDR_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
   endtask

   // upper data bits beyond each period and trial-limit register's width carry junk
   task automatic write_config(input cfg_type c);
      put_reg(CSR_UNLOCK_CODE, c.unlock_code);
      put_reg(CSR_ENTRY_TIMEOUT, {8'($urandom), c.entry_timeout});
      put_reg(CSR_OPEN_TIME, {8'($urandom), c.open_time});
      put_reg(CSR_DENIED_TIME, {8'($urandom), c.denied_time});
      put_reg(CSR_LOCKOUT_TIME, {8'($urandom), c.lockout_time});
      put_reg(CSR_ALARM_TIME, {8'($urandom), c.alarm_time});
      put_reg(CSR_TRIAL_LIMIT, {11'($urandom), c.trial_limit});
      put_reg(CSR_UNMAPPED, 14'($urandom));
      csr_write <= 1'b0;
      code_now = c.unlock_code;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (lock_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one user interaction: press, key in a code, then let the lock run; or a run of random items
   task automatic run_session();
      int         n;
      int         len;
      int         v;
      int         k;
      logic [7:0] keys[$];
      if (coin(15)) begin
         n = $urandom_range(5, 30);
         repeat (n) drive_item(make_item(coin(50), coin(50), 8'($urandom), coin(tick_pct)));
      end else begin
         drive_item(make_item(1'b0, coin(20), 8'($urandom), coin(tick_pct)));
         drive_item(make_item(1'b1, 1'b0, 8'($urandom), coin(tick_pct)));
         v = coin(35) ? code_now % 10000 : $urandom_range(0, 9999);
         len = (v >= 1000) ? 4 : (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
         len = $urandom_range(len, 4);
         for (k = 0; k < len; k++) begin
            keys.push_front(ASCII_ZERO + 8'(v % 10));
            v = v / 10;
         end
         // terminator with no digit yet is ignored
         if (coin(10)) keys.push_front(coin(50) ? ASCII_CR : ASCII_LF);
         if ((len < 4 && !coin(8)) || coin(10)) keys.push_back(coin(50) ? ASCII_CR : ASCII_LF);
         for (k = 0; k < keys.size(); k++) begin
            if (coin(20)) drive_item(make_item(coin(30), coin(50), 8'($urandom), coin(tick_pct)));
            drive_item(make_item(coin(30), 1'b1, keys[k], coin(tick_pct)));
         end
         n = $urandom_range(2, tail_max);
         repeat (n) drive_item(make_item(coin(8), coin(10), 8'($urandom), coin(tick_pct)));
      end
   endtask

   // result side: random stall, plus one long hold-off on request
   initial begin
      int   len;
      int   pick;
      logic stall_val;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (rsp_burst || pick < 50) begin
               stall_val = 1'b0;
               len = $urandom_range(1, 8);
            end else if (pick < 75) begin
               stall_val = 1'b1;
               len = $urandom_range(1, 3);
            end else if (pick < 90) begin
               stall_val = 1'b0;
               len = $urandom_range(10, 30);
            end else if (pick < 97) begin
               stall_val = 1'b1;
               len = $urandom_range(4, 12);
            end else begin
               stall_val = 1'b1;
               len = $urandom_range(20, 40);
            end
            rsp_stall <= stall_val;
            repeat (len) @(negedge clock);
         end
      end
   end

   initial begin
      cfg_type c;
      int      p;
      int      phase_end;
      int      maxp;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through every state and event
      write_config(make_cfg(9999, 1, 1, 1, 2, 1, 2));
      drive_item(make_item(1'b0, 1'b1, 8'hFF, 1'b0));
      drive_item(make_item(1'b1, 1'b0, 8'h00, 1'b0));
      drive_item(make_item(1'b1, 1'b1, 8'h00, 1'b0));
      drive_item(make_item(1'b1, 1'b1, ASCII_CR, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_NINE, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_NINE, 1'b0));
      drive_item(make_item(1'b1, 1'b1, ASCII_NINE, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_NINE, 1'b0));
      drive_item(make_item(1'b0, 1'b0, 8'h00, 1'b1));
      drive_item(make_item(1'b1, 1'b0, 8'h00, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_ZERO, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_LF, 1'b0));
      drive_item(make_item(1'b0, 1'b0, 8'h00, 1'b1));
      drive_item(make_item(1'b1, 1'b0, 8'h00, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_ZERO + 8'd5, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_CR, 1'b0));
      drive_item(make_item(1'b0, 1'b0, 8'h00, 1'b0));
      drive_item(make_item(1'b1, 1'b0, 8'h00, 1'b0));
      drive_item(make_item(1'b0, 1'b0, 8'h00, 1'b1));
      drive_item(make_item(1'b1, 1'b0, 8'h00, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_ZERO + 8'd7, 1'b0));
      drive_item(make_item(1'b0, 1'b1, ASCII_CR, 1'b1));
      drive_item(make_item(1'b0, 1'b1, ASCII_ZERO + 8'd7, 1'b1));
      drain();

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               c = make_cfg(0, 1, 1, 1, 1, 1, 1);
               tick_pct = 50;
            end
            1: begin
               // zero periods and zero trial limit act as one
               c = make_cfg(16383, 0, 0, 0, 0, 0, 0);
               tick_pct = 50;
            end
            2: begin
               c = make_cfg(9999, 63, 63, 63, 63, 63, 7);
               tick_pct = 90;
            end
            default: begin
               c = make_cfg($urandom_range(0, 9999), pick_period(), pick_period(),
                            pick_period(), pick_period(), pick_period(),
                            $urandom_range(0, 7));
               tick_pct = $urandom_range(15, 70);
            end
         endcase
         maxp = 1;
         if (c.open_time > maxp) maxp = c.open_time;
         if (c.denied_time > maxp) maxp = c.denied_time;
         if (c.lockout_time > maxp) maxp = c.lockout_time;
         if (c.alarm_time > maxp) maxp = c.alarm_time;
         tail_max = 4 + (maxp * 150) / tick_pct;
         if (tail_max > 160) tail_max = 160;
         req_burst = (p % 4 == 2) || (p == 3);
         rsp_burst = (p % 4 == 2);
         write_config(c);
         // fill the block while the result side holds off
         if (p == 3) hold_off = 1'b1;
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) run_session();
         drain();
      end

      if (lock_errors == 0 && lock_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ code_lock_controller.f @@
sv/cllc_pkg.sv
sv/cllc_csr.sv
sv/cllc_fsm.sv
sv/code_lock_controller.sv
tb/code_lock_checker.sv
tb/code_lock_controller_tb.sv
